// ===== design/bounded_double_ended_queue_defines.svh =====
// Assertion macros used by the checker of the deque.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define BDQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence in the following cycle.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/bdq_pkg.sv =====
package bdq_pkg;

    localparam int DEPTH  = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam int CAP_W  = 11;
    localparam int CMD_W  = 3;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1024);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_REAR  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_REAR   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_QUERY      = 3'd4;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic signed [DATA_W-1:0] data_value;
    } in_item_t;

    typedef struct packed {
        logic                     success;
        logic signed [DATA_W-1:0] front_value;
        logic signed [DATA_W-1:0] rear_value;
        logic                     is_empty;
        logic                     is_full;
    } out_item_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LOAD
    } state_t;

endpackage

// ===== design/bounded_double_ended_queue.sv =====
// Channel  Direction  Handshake            Payload
// in       input      in_valid / in_stall  in_data  (cmd, data_value)
// out      output     out_valid/ out_stall out_data (success, front, rear, empty, full)
// cfg      input      cfg_wr_en            cfg_wr_data (capacity)
//
// Each command passes through S_IDLE and S_LOAD: the accept cycle updates head and count and
// issues the single entry-memory access; S_LOAD takes the registered read data and loads the
// output register once that register is free or being taken, so a stalled result holds S_LOAD.
// Reset clears head, count and capacity (to 1024); the entry memory needs no clearing pass.
// A stalled result holds in the output register; the next command is still accepted.
module bounded_double_ended_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bdq_pkg::in_item_t in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output bdq_pkg::out_item_t out_data,
    input  logic              cfg_wr_en,
    input  logic [bdq_pkg::CAP_W-1:0] cfg_wr_data
);
    import bdq_pkg::*;

    logic [DATA_W-1:0] mem [DEPTH];

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [CAP_W-1:0]  cap_reg;
    logic              out_valid_reg;
    out_item_t         out_data_reg;

    logic [DATA_W-1:0] front_reg, rear_reg, rd_data_reg;
    logic              ok_reg, ref_front_reg, ref_rear_reg;

    logic              accept, load_out;
    logic [CAP_W-1:0]  cap_eff;
    logic              full, empty;
    logic              do_push_f, do_push_r, do_pop_f, do_pop_r;
    logic              mem_wr_en, mem_rd_en;
    logic [ADDR_W-1:0] mem_wr_addr, mem_rd_addr;
    logic [DATA_W-1:0] front_cur, rear_cur;
    logic              cmd_ok;

    assign cap_eff = (cap_reg > CAP_W'(DEPTH)) ? CAP_W'(DEPTH) : cap_reg;
    assign full    = CAP_W'(count_reg) >= cap_eff;
    assign empty   = (count_reg == '0);
    assign accept  = in_valid && !in_stall;

    assign do_push_f = accept && (in_data.cmd == CMD_PUSH_FRONT) && !full;
    assign do_push_r = accept && (in_data.cmd == CMD_PUSH_REAR) && !full;
    assign do_pop_f  = accept && (in_data.cmd == CMD_POP_FRONT) && !empty;
    assign do_pop_r  = accept && (in_data.cmd == CMD_POP_REAR) && !empty;

    always_comb
    begin
        case (in_data.cmd)
            CMD_PUSH_FRONT, CMD_PUSH_REAR: cmd_ok = !full;
            CMD_POP_FRONT, CMD_POP_REAR:   cmd_ok = !empty;
            CMD_QUERY:                     cmd_ok = 1'b1;
            default:                       cmd_ok = 1'b0;
        endcase
    end

    // A push writes and a pop reads in the accept cycle of different commands, and every
    // accept is followed by S_LOAD, so a read never overlaps a write to the same entry.
    assign mem_wr_en   = do_push_f || do_push_r;
    assign mem_wr_addr = do_push_f ? (head_reg - 1'b1) : (head_reg + count_reg[ADDR_W-1:0]);
    assign mem_rd_en   = do_pop_f || do_pop_r;
    assign mem_rd_addr = do_pop_f ? (head_reg + 1'b1)
                                  : (head_reg + count_reg[ADDR_W-1:0] - ADDR_W'(2));

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        if (do_push_f)
        begin
            head_next  = head_reg - 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (do_push_r)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop_f)
        begin
            head_next  = head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
        else if (do_pop_r)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_LOAD;
            S_LOAD:  if (load_out) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // FSM outputs.
    always_comb
    begin
        in_stall = 1'b1;
        load_out = 1'b0;
        case (state_reg)
            S_IDLE:  in_stall = 1'b0;
            S_LOAD:  load_out = !out_valid_reg || !out_stall;
            default: in_stall = 1'b1;
        endcase
    end

    assign front_cur = ref_front_reg ? rd_data_reg : front_reg;
    assign rear_cur  = ref_rear_reg ? rd_data_reg : rear_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= cmd_ok;
            ref_front_reg <= do_pop_f;
            ref_rear_reg  <= do_pop_r;
            if (do_push_f)
            begin
                front_reg <= in_data.data_value;
                if (empty)
                    rear_reg <= in_data.data_value;
            end
            if (do_push_r)
            begin
                rear_reg <= in_data.data_value;
                if (empty)
                    front_reg <= in_data.data_value;
            end
        end
        if (load_out)
        begin
            front_reg                <= front_cur;
            rear_reg                 <= rear_cur;
            out_data_reg.success     <= ok_reg;
            out_data_reg.front_value <= empty ? '1 : front_cur;
            out_data_reg.rear_value  <= empty ? '1 : rear_cur;
            out_data_reg.is_empty    <= empty;
            out_data_reg.is_full     <= full;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_wr_en)
            mem[mem_wr_addr] <= in_data.data_value;
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd_en)
            rd_data_reg <= mem[mem_rd_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== design/bdq_checker.sv =====
`include "bounded_double_ended_queue_defines.svh"

module bdq_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input bdq_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_stall,
    input bdq_pkg::out_item_t out_data
);
    import bdq_pkg::*;

    logic in_take, out_take, out_hold;

    assign in_take  = in_valid && !in_stall;
    assign out_take = out_valid && !out_stall;
    assign out_hold = out_valid && out_stall;

    // Hold a stalled result unchanged.
    `BDQ_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_data), "stalled transaction changed")
    // Stall the input for the cycle after a transaction is taken.
    `BDQ_ASSERT_NEXT(a_in_busy, in_take, in_stall, "input taken on consecutive cycles")
    // Report -1 at both ends when empty.
    `BDQ_ASSERT_NOW(a_empty_vals, out_take && out_data.is_empty, (out_data.front_value == -32'sd1) && (out_data.rear_value == -32'sd1), "empty deque with live end values")
    // Keep the success flag known while a result is offered.
    `BDQ_ASSERT(a_out_known, !out_valid || !$isunknown(out_data.success), "result flag unknown")

endmodule

bind bounded_double_ended_queue bdq_checker u_bdq_checker (.*);
